// File: src/abps_pkg.sv
`timescale 1ns / 1ps
// Package for the alarm beep pattern sequencer: warning codes, LED codes,
// beat and battery constants, and the beep pattern helpers. No dependencies.
package abps_pkg;

  localparam int unsigned NUM_WARNINGS = 9;

  localparam logic [3:0] WARN_INIT    = 4'd0;
  localparam logic [3:0] WARN_GYRO    = 4'd1;
  localparam logic [3:0] WARN_ACC     = 4'd2;
  localparam logic [3:0] WARN_ADC     = 4'd3;
  localparam logic [3:0] WARN_BATTERY = 4'd4;
  localparam logic [3:0] WARN_COMPASS = 4'd5;
  localparam logic [3:0] WARN_MAGFS   = 4'd6;
  localparam logic [3:0] WARN_MAGINC  = 4'd7;
  localparam logic [3:0] WARN_GPS     = 4'd8;
  localparam logic [3:0] WARN_NONE    = 4'd9;

  localparam logic [1:0] LED_LEAVE = 2'd0;
  localparam logic [1:0] LED_OFF   = 2'd1;
  localparam logic [1:0] LED_BLUE  = 2'd2;

  localparam logic [2:0] REG_BATTERY_LOW  = 3'd0;
  localparam logic [2:0] REG_BATTERY_HIGH = 3'd1;
  localparam logic [2:0] REG_BATTERY_STEP = 3'd2;
  localparam logic [2:0] REG_BEEP_ENABLE  = 3'd3;

  localparam logic [15:0] BATTERY_LOW_RESET  = 16'd10100;
  localparam logic [15:0] BATTERY_HIGH_RESET = 16'd10700;
  localparam logic [7:0]  BATTERY_STEP_RESET = 8'd6;
  localparam logic [1:0]  BEEP_ENABLE_RESET  = 2'd3;

  localparam logic [7:0] BEAT_LAST     = 8'd199;
  localparam logic [7:0] HALF_BEAT     = 8'd100;
  localparam logic [6:0] PHASE_LAST    = 7'd99;
  localparam logic [7:0] DEBOUNCE_KEEP = 8'd10;
  localparam logic [7:0] DEBOUNCE_DROP = 8'd2;

  localparam logic [6:0] SPAN_COMPASS = 7'd50;
  localparam logic [6:0] SPAN_MAGFS   = 7'd30;
  localparam logic [6:0] SPAN_MAGINC  = 7'd40;

  // on for ticks 0-4, 10-14, 20-24 ... of the half beat, up to span
  function automatic logic pulse_train(input logic [6:0] m, input logic [6:0] span);
    logic on;
    on = 1'b0;
    for (int k = 0; k < 5; k++) begin
      if (m >= 7'(10 * k) && m < 7'(10 * k + 5)) on = 1'b1;
    end
    return on && (m < span);
  endfunction

  function automatic logic in_window(input logic [7:0] c, input logic [7:0] lo,
                                     input logic [7:0] hi);
    return (c >= lo) && (c < hi);
  endfunction

endpackage

// File: src/alarm_beep_pattern_sequencer_core.sv
`timescale 1ns / 1ps
// The result of an accepted input beat is registered in the cycle after it.
// Throughput: one tick beat per cycle unless stalled; all tick logic sits
// between the input ports and the result register, with one 7x8 multiply for
// the battery pattern. Reset: synchronous, clears counters, hysteresis and
// timeouts, loads register defaults, and empties the result register.
// Top level of the alarm beep pattern sequencer; uses abps_pkg.
module alarm_beep_pattern_sequencer_core #(
  parameter int TICKS_PER_SECOND = 100,
  parameter int MAG_WARN_TICKS   = 400
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [15:0] battery_mv,
  input  logic        gps_locked,
  input  logic        rc_gps_mode,
  input  logic [5:0]  error_flags,
  input  logic        system_ready,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        buzzer_on,
  output logic [1:0]  led_action,
  output logic [3:0]  winning_warning
);

  localparam logic [7:0] DEBOUNCE_LIMIT = 8'(TICKS_PER_SECOND / 5);
  localparam logic [8:0] MAG_LIMIT      = 9'(MAG_WARN_TICKS);

  logic [15:0] battery_low_mv, battery_high_mv;
  logic [7:0]  battery_step_mv;
  logic [1:0]  beep_enable_mask;

  logic [7:0] beat_count, beat_count_next;
  logic [6:0] battery_phase, battery_phase_next;
  logic [7:0] battery_debounce, battery_debounce_next;
  logic       battery_alarm_armed, battery_alarm_armed_next;
  logic [8:0] compass_timeout, compass_timeout_next;
  logic [8:0] mag_strength_timeout, mag_strength_timeout_next;
  logic [8:0] mag_incline_timeout, mag_incline_timeout_next;

  logic        accept;
  logic [6:0]  m;
  logic [15:0] vbat, headroom;
  logic [14:0] threshold;
  logic        compass_gate, magfs_gate, maginc_gate;
  logic [abps_pkg::NUM_WARNINGS-1:0] pri, act;
  logic        buzz;
  logic [1:0]  led;
  logic [3:0]  win;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    beat_count_next    = (beat_count >= abps_pkg::BEAT_LAST) ? 8'd0 : beat_count + 8'd1;
    battery_phase_next = (battery_phase >= abps_pkg::PHASE_LAST) ? 7'd0
                                                                 : battery_phase + 7'd1;
    m = (beat_count_next >= abps_pkg::HALF_BEAT) ?
        7'(beat_count_next - abps_pkg::HALF_BEAT) : 7'(beat_count_next);

    vbat = (battery_mv < battery_low_mv) ? battery_low_mv : battery_mv;
    battery_debounce_next    = battery_debounce;
    battery_alarm_armed_next = battery_alarm_armed;
    if (vbat < battery_high_mv) begin
      if (battery_debounce < DEBOUNCE_LIMIT) battery_debounce_next = battery_debounce + 8'd1;
      else battery_alarm_armed_next = 1'b1;
    end else begin
      if (battery_debounce > abps_pkg::DEBOUNCE_KEEP)
        battery_debounce_next = battery_debounce - abps_pkg::DEBOUNCE_DROP;
      else battery_alarm_armed_next = 1'b0;
    end
    headroom  = vbat - battery_low_mv;
    threshold = 15'(battery_phase_next) * 15'(battery_step_mv);

    compass_gate = system_ready && error_flags[3] && (compass_timeout < MAG_LIMIT);
    magfs_gate   = system_ready && error_flags[4] && (mag_strength_timeout < MAG_LIMIT);
    maginc_gate  = system_ready && error_flags[5] && (mag_incline_timeout < MAG_LIMIT);
    compass_timeout_next      = compass_gate ? compass_timeout + 9'd1 : compass_timeout;
    mag_strength_timeout_next = magfs_gate ? mag_strength_timeout + 9'd1
                                           : mag_strength_timeout;
    mag_incline_timeout_next  = maginc_gate ? mag_incline_timeout + 9'd1
                                            : mag_incline_timeout;

    pri = '0;
    act = '0;
    led = abps_pkg::LED_LEAVE;

    pri[abps_pkg::WARN_BATTERY] = battery_alarm_armed_next;
    act[abps_pkg::WARN_BATTERY] = battery_alarm_armed_next && (headroom < {1'b0, threshold});

    pri[abps_pkg::WARN_GPS] = beep_enable_mask[1] && !gps_locked && rc_gps_mode;
    act[abps_pkg::WARN_GPS] = pri[abps_pkg::WARN_GPS] && (beat_count_next < 8'd5);

    if (system_ready) begin
      pri[abps_pkg::WARN_GYRO] = error_flags[0];
      act[abps_pkg::WARN_GYRO] = error_flags[0] &&
        (beat_count_next < 8'd155 || abps_pkg::in_window(beat_count_next, 8'd160, 8'd165));
      pri[abps_pkg::WARN_ACC] = error_flags[1];
      act[abps_pkg::WARN_ACC] = error_flags[1] &&
        (beat_count_next < 8'd145 || abps_pkg::in_window(beat_count_next, 8'd150, 8'd155) ||
         abps_pkg::in_window(beat_count_next, 8'd160, 8'd165));
      pri[abps_pkg::WARN_ADC] = error_flags[2];
      act[abps_pkg::WARN_ADC] = error_flags[2] &&
        (beat_count_next < 8'd135 || abps_pkg::in_window(beat_count_next, 8'd140, 8'd145) ||
         abps_pkg::in_window(beat_count_next, 8'd150, 8'd155) ||
         abps_pkg::in_window(beat_count_next, 8'd160, 8'd165));
      pri[abps_pkg::WARN_COMPASS] = compass_gate;
      act[abps_pkg::WARN_COMPASS] = compass_gate &&
                                    abps_pkg::pulse_train(m, abps_pkg::SPAN_COMPASS);
      pri[abps_pkg::WARN_MAGFS] = magfs_gate;
      act[abps_pkg::WARN_MAGFS] = magfs_gate && abps_pkg::pulse_train(m, abps_pkg::SPAN_MAGFS);
      pri[abps_pkg::WARN_MAGINC] = maginc_gate;
      act[abps_pkg::WARN_MAGINC] = maginc_gate &&
                                   abps_pkg::pulse_train(m, abps_pkg::SPAN_MAGINC);
    end else if (beep_enable_mask[0]) begin
      pri[abps_pkg::WARN_INIT] = 1'b1;
      if (m < 7'd5 || (m >= 7'd10 && m < 7'd15) || (m >= 7'd30 && m < 7'd35)) begin
        act[abps_pkg::WARN_INIT] = 1'b1;
        led = abps_pkg::LED_BLUE;
      end else begin
        led = abps_pkg::LED_OFF;
      end
    end

    win  = abps_pkg::WARN_NONE;
    buzz = 1'b0;
    for (int i = abps_pkg::NUM_WARNINGS - 1; i >= 0; i--) begin
      if (pri[i]) begin
        win  = 4'(i);
        buzz = act[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_low_mv       <= abps_pkg::BATTERY_LOW_RESET;
      battery_high_mv      <= abps_pkg::BATTERY_HIGH_RESET;
      battery_step_mv      <= abps_pkg::BATTERY_STEP_RESET;
      beep_enable_mask     <= abps_pkg::BEEP_ENABLE_RESET;
      beat_count           <= '0;
      battery_phase        <= '0;
      battery_debounce     <= '0;
      battery_alarm_armed  <= 1'b0;
      compass_timeout      <= '0;
      mag_strength_timeout <= '0;
      mag_incline_timeout  <= '0;
      result_valid         <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          abps_pkg::REG_BATTERY_LOW:  battery_low_mv   <= cfg_data;
          abps_pkg::REG_BATTERY_HIGH: battery_high_mv  <= cfg_data;
          abps_pkg::REG_BATTERY_STEP: battery_step_mv  <= cfg_data[7:0];
          abps_pkg::REG_BEEP_ENABLE:  beep_enable_mask <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (accept) begin
        beat_count           <= beat_count_next;
        battery_phase        <= battery_phase_next;
        battery_debounce     <= battery_debounce_next;
        battery_alarm_armed  <= battery_alarm_armed_next;
        compass_timeout      <= compass_timeout_next;
        mag_strength_timeout <= mag_strength_timeout_next;
        mag_incline_timeout  <= mag_incline_timeout_next;
        result_valid         <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buzzer_on       <= buzz;
      led_action      <= led;
      winning_warning <= win;
    end
  end

endmodule
